@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

@@ design/erm_pkg.sv @@
// Shared types and constants for the Euler rotation matrix block.
`timescale 1ns / 1ps
package erm_pkg;
    localparam int unsigned ZW = 34;
    localparam int unsigned XW = 34;
    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

    function automatic logic signed [ZW-1:0] atan_turn(input int unsigned i);
        logic signed [ZW-1:0] t;
        begin
            unique case (i)
                0: t = 34'sd536870912;  1: t = 34'sd316933406;
                2: t = 34'sd167458907;  3: t = 34'sd85004756;
                4: t = 34'sd42667331;   5: t = 34'sd21354465;
                6: t = 34'sd10679838;   7: t = 34'sd5340245;
                8: t = 34'sd2670163;    9: t = 34'sd1335087;
                10: t = 34'sd667544;    11: t = 34'sd333772;
                12: t = 34'sd166886;    13: t = 34'sd83443;
                14: t = 34'sd41722;     15: t = 34'sd20861;
                16: t = 34'sd10430;     17: t = 34'sd5215;
                18: t = 34'sd2608;      19: t = 34'sd1304;
                20: t = 34'sd652;       21: t = 34'sd326;
                22: t = 34'sd163;       23: t = 34'sd81;
                24: t = 34'sd41;        25: t = 34'sd20;
                26: t = 34'sd10;        27: t = 34'sd5;
                28: t = 34'sd3;         29: t = 34'sd1;
                30: t = 34'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction
endpackage

@@ design/euler_rotation_matrix_3x3.sv @@
// An input transfer reaches output valid through the CORDIC stages and the three product stages.
// Throughput: one angle triple per cycle while the output is not stalled; set by the unrolled CORDIC
// and three-stage product pipeline, in which each stage moves when the one after it is empty or moving.
// A stall at the output holds the full stages that have no empty stage after them; empty stages still fill.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module euler_rotation_matrix_3x3 #(
    parameter int ANGLE_BITS   = 16,
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // angle_x [15:0], angle_y [31:16], angle_z [47:32]
    input  logic [47:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // r00 [15:0] r01 r02 r10 r11 r12 r20 r21 r22 [143:128]
    output logic [143:0] m_axis_tdata
);
    localparam int N  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int CD = N + 2;
    localparam int D  = CD + 3;
    localparam int AW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;
    localparam int OW = FRAC_BITS + 2;

    logic [D-1:0] r_vld;
    logic [D-1:0] en;
    logic         adv;

    // a stage moves when the one after it is empty or moving
    always_comb begin
        adv = !r_vld[D-1] || m_axis_tready;
        en[D-1] = adv;
        for (int k = D - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_vld[D-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < D; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    logic [ANGLE_BITS-1:0] ax, ay, az;
    assign ax = ANGLE_BITS'(s_axis_tdata[AW-1:0]);
    assign ay = ANGLE_BITS'(s_axis_tdata[16 +: AW]);
    assign az = ANGLE_BITS'(s_axis_tdata[32 +: AW]);

    logic [CD-1:0] cen;
    assign cen = en[CD-1:0] & {r_vld[CD-2:0], s_axis_tvalid};

    logic signed [OW-1:0] cx, sx, cy, sy, cz, sz;
    erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS), .DEPTH(CD)) u_cx (
        .i_clk(i_clk), .i_en(cen), .i_angle(ax), .o_cos(cx), .o_sin(sx));
    erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS), .DEPTH(CD)) u_cy (
        .i_clk(i_clk), .i_en(cen), .i_angle(ay), .o_cos(cy), .o_sin(sy));
    erm_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS), .DEPTH(CD)) u_cz (
        .i_clk(i_clk), .i_en(cen), .i_angle(az), .o_cos(cz), .o_sin(sz));

    erm_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
        .i_clk(i_clk), .i_en(en[D-1:CD] & r_vld[D-2:CD-1]),
        .i_cx(cx), .i_sx(sx), .i_cy(cy), .i_sy(sy), .i_cz(cz), .i_sz(sz),
        .o_elems(m_axis_tdata));

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "drop")
    `ASSERT_IMPL(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "idle stall")
    `ASSERT_NEXT(a_fill, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_vld[0], "lost")
endmodule

@@ design/erm_cordic.sv @@
// Unrolled CORDIC pipeline giving sine and cosine of one binary angle.
`timescale 1ns / 1ps
module erm_cordic #(
    parameter int ANGLE_BITS   = 16,
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16,
    parameter int DEPTH        = CORDIC_STEPS + 2
) (
    input  logic                   i_clk,
    input  logic [DEPTH-1:0]       i_en,
    input  logic [ANGLE_BITS-1:0]  i_angle,
    output logic signed [FRAC_BITS+1:0] o_cos,
    output logic signed [FRAC_BITS+1:0] o_sin
);
    localparam int N  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int XW = erm_pkg::XW;
    localparam int ZW = erm_pkg::ZW;
    localparam int SH = 30 - FRAC_BITS;
    localparam int OW = FRAC_BITS + 2;
    localparam logic signed [XW-1:0] ONE  = XW'(1) <<< FRAC_BITS;
    localparam logic signed [XW-1:0] HALF = XW'(1) <<< (SH - 1);

    logic signed [XW-1:0] r_x [0:N];
    logic signed [XW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0] <= erm_pkg::GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= ZW'({i_angle[ANGLE_BITS-3:0], {(34 - ANGLE_BITS){1'b0}}}) >>> 2;
            r_q[0] <= i_angle[ANGLE_BITS-1 -: 2];
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_it
        always_ff @(posedge i_clk) begin
            if (i_en[i+1]) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - erm_pkg::atan_turn(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + erm_pkg::atan_turn(i);
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    logic signed [XW-1:0] c_rnd, s_rnd, c_sat, s_sat;
    always_comb begin
        c_rnd = (r_x[N] + HALF) >>> SH;
        s_rnd = (r_y[N] + HALF) >>> SH;
        c_sat = (c_rnd > ONE) ? ONE : ((c_rnd < -ONE) ? -ONE : c_rnd);
        s_sat = (s_rnd > ONE) ? ONE : ((s_rnd < -ONE) ? -ONE : s_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[N+1]) begin
            unique case (r_q[N])
                2'd0: begin o_cos <= OW'(c_sat);  o_sin <= OW'(s_sat);  end
                2'd1: begin o_cos <= OW'(-s_sat); o_sin <= OW'(c_sat);  end
                2'd2: begin o_cos <= OW'(-c_sat); o_sin <= OW'(-s_sat); end
                default: begin o_cos <= OW'(s_sat); o_sin <= OW'(-c_sat); end
            endcase
        end
    end
endmodule

@@ design/erm_matrix.sv @@
// Product and sum pipeline forming the nine matrix elements.
`timescale 1ns / 1ps
module erm_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic [2:0]                  i_en,
    input  logic signed [FRAC_BITS+1:0] i_cx, i_sx, i_cy, i_sy, i_cz, i_sz,
    output logic [143:0]                o_elems
);
    localparam int OW = FRAC_BITS + 2;
    localparam int PW = 2 * OW + 2;
    localparam logic signed [PW-1:0] ONE  = PW'(1) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction
    function automatic logic signed [PW-1:0] sat(input logic signed [PW-1:0] v);
        return (v > ONE) ? ONE : ((v < -ONE) ? -ONE : v);
    endfunction

    // stage 1: two-factor products
    logic signed [PW-1:0] r_sysx, r_cysx, r_cycz, r_cysz, r_sycz, r_sysz;
    logic signed [PW-1:0] r_sycx, r_cxsz, r_cxcz, r_cycx;
    logic signed [OW-1:0] r_cz1, r_sz1, r_sx1;
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sysx <= PW'(i_sy * i_sx); r_cysx <= PW'(i_cy * i_sx);
            r_cycz <= PW'(i_cy * i_cz); r_cysz <= PW'(i_cy * i_sz);
            r_sycz <= PW'(i_sy * i_cz); r_sysz <= PW'(i_sy * i_sz);
            r_sycx <= PW'(i_sy * i_cx); r_cxsz <= PW'(i_cx * i_sz);
            r_cxcz <= PW'(i_cx * i_cz); r_cycx <= PW'(i_cy * i_cx);
            r_cz1 <= i_cz; r_sz1 <= i_sz; r_sx1 <= i_sx;
        end
    end

    // stage 2: third factor on the rounded sx products
    logic signed [PW-1:0] r_a0, r_a1, r_a6, r_a7, r_b0, r_b1, r_b6, r_b7;
    logic signed [PW-1:0] r_e2, r_e3, r_e4, r_e5, r_e8;
    logic signed [OW-1:0] p, q;
    always_comb begin
        p = OW'(rnd(r_sysx));
        q = OW'(rnd(r_cysx));
    end
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_a0 <= PW'(p * r_sz1); r_b0 <= r_cycz;
            r_a1 <= PW'(p * r_cz1); r_b1 <= -r_cysz;
            r_a6 <= PW'(q * r_sz1); r_b6 <= -r_sycz;
            r_a7 <= PW'(q * r_cz1); r_b7 <= r_sysz;
            r_e2 <= sat(rnd(r_sycx)); r_e3 <= sat(rnd(r_cxsz));
            r_e4 <= sat(rnd(r_cxcz)); r_e8 <= sat(rnd(r_cycx));
            r_e5 <= sat(-PW'(r_sx1));
        end
    end

    // stage 3: sum, round and saturate
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_elems[0*16 +: 16]  <= 16'(sat(rnd(r_a0 + r_b0)));
            o_elems[1*16 +: 16]  <= 16'(sat(rnd(r_a1 + r_b1)));
            o_elems[2*16 +: 16]  <= 16'(r_e2);
            o_elems[3*16 +: 16]  <= 16'(r_e3);
            o_elems[4*16 +: 16]  <= 16'(r_e4);
            o_elems[5*16 +: 16]  <= 16'(r_e5);
            o_elems[6*16 +: 16]  <= 16'(sat(rnd(r_a6 + r_b6)));
            o_elems[7*16 +: 16]  <= 16'(sat(rnd(r_a7 + r_b7)));
            o_elems[8*16 +: 16]  <= 16'(r_e8);
        end
    end
endmodule
